// ===== rtl/hcm_pkg.sv =====
// ----------------------------------------------------------------------------
// hcm_pkg
// Shared types and constants for the hash count majority block.
// ----------------------------------------------------------------------------
package hcm_pkg;

  localparam int TABLE_SIZE_DEF = 4096;
  localparam int KEY_BITS_DEF   = 16;
  localparam int COUNT_BITS_DEF = 16;

  // Width of the set number kept with every slot. A slot is valid only when
  // its stored set number equals the current one.
  localparam int EPOCH_BITS = 8;

  localparam int              PROBE_BITS  = 5;
  localparam logic [PROBE_BITS-1:0] PROBE_RESET = 5'd10;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_PROBE
  } hcm_state_t;

  typedef struct packed {
    logic stored_ok;
    logic end_of_set;
    logic has_majority;
  } hcm_flags_t;

endpackage

// ===== rtl/hcm_slot_ram.sv =====
// ----------------------------------------------------------------------------
// hcm_slot_ram
// Single-port synchronous slot table with a registered read.
// ----------------------------------------------------------------------------
module hcm_slot_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 40
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/hcm_engine.sv =====
// ----------------------------------------------------------------------------
// hcm_engine
// Probe sequencer: hashes the key, streams reads through the probe window,
// writes back the updated slot, keeps the set counters and wipes the table.
// ----------------------------------------------------------------------------
module hcm_engine
  import hcm_pkg::*;
#(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     start,
  output logic                                     busy,
  input  logic [KEY_BITS-1:0]                      in_color,
  input  logic                                     in_last,
  input  logic [PROBE_BITS-1:0]                    probe_limit,
  output logic                                     ram_we,
  output logic [$clog2(TABLE_SIZE)-1:0]            ram_addr,
  output logic [EPOCH_BITS+KEY_BITS+COUNT_BITS-1:0] ram_wdata,
  input  logic [EPOCH_BITS+KEY_BITS+COUNT_BITS-1:0] ram_rdata,
  output logic                                     out_valid,
  output hcm_flags_t                               out_flags,
  output logic [KEY_BITS-1:0]                      out_color
);

  localparam int ADDR_BITS = $clog2(TABLE_SIZE);
  localparam int WORD_BITS = EPOCH_BITS + KEY_BITS + COUNT_BITS;
  localparam int KEY_EXT   = (KEY_BITS > ADDR_BITS) ? KEY_BITS : ADDR_BITS;
  localparam int KIDX      = $clog2(KEY_BITS);
  localparam bit POW2      = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;
  localparam logic [ADDR_BITS-1:0]  LAST_SLOT = ADDR_BITS'(TABLE_SIZE - 1);
  localparam logic [ADDR_BITS:0]    TSIZE     = (ADDR_BITS + 1)'(TABLE_SIZE);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  hcm_state_t state_r, state_nxt;

  logic [KEY_BITS-1:0]   key_r, key_nxt;
  logic                  last_r, last_nxt;
  logic [ADDR_BITS-1:0]  pos_r, pos_nxt;
  logic [ADDR_BITS-1:0]  chk_pos_r, chk_pos_nxt;
  logic                  rd_pend_r, rd_pend_nxt;
  logic [PROBE_BITS-1:0] n_iss_r, n_iss_nxt;
  logic                  have_empty_r, have_empty_nxt;
  logic [ADDR_BITS-1:0]  empty_pos_r, empty_pos_nxt;
  logic [ADDR_BITS-1:0]  rem_r, rem_nxt;
  logic [KIDX-1:0]       hash_idx_r, hash_idx_nxt;
  logic [ADDR_BITS-1:0]  clr_addr_r, clr_addr_nxt;
  logic [EPOCH_BITS-1:0] epoch_r, epoch_nxt;
  logic [COUNT_BITS-1:0] items_r, items_nxt;
  logic [COUNT_BITS-1:0] best_tally_r, best_tally_nxt;
  logic [KEY_BITS-1:0]   best_key_r, best_key_nxt;
  logic                  out_valid_r, out_valid_nxt;
  hcm_flags_t            flags_r, flags_nxt;
  logic [KEY_BITS-1:0]   color_r, color_nxt;

  logic [KEY_EXT-1:0]    key_ext;
  logic [EPOCH_BITS-1:0] rd_epoch;
  logic [KEY_BITS-1:0]   rd_key;
  logic [COUNT_BITS-1:0] rd_tally;
  logic                  hit;
  logic                  empty_now;
  logic                  issue;
  logic                  done_probe;
  logic                  ok;
  logic [COUNT_BITS-1:0] tally_inc;
  logic [COUNT_BITS-1:0] new_tally;
  logic [COUNT_BITS-1:0] items_inc;
  logic [COUNT_BITS-1:0] best_upd;
  logic [KEY_BITS-1:0]   best_key_upd;
  logic [ADDR_BITS:0]    rem_shift;
  logic [ADDR_BITS:0]    rem_red;
  logic [ADDR_BITS-1:0]  pos_inc;
  logic [EPOCH_BITS-1:0] epoch_inc;

  assign key_ext  = KEY_EXT'(in_color);
  assign rd_epoch = ram_rdata[WORD_BITS-1 -: EPOCH_BITS];
  assign rd_key   = ram_rdata[COUNT_BITS +: KEY_BITS];
  assign rd_tally = ram_rdata[COUNT_BITS-1:0];

  // A slot written in an earlier set carries an older set number and reads
  // as empty.
  assign hit        = rd_pend_r && (rd_epoch == epoch_r) && (rd_key == key_r);
  assign empty_now  = rd_pend_r && (rd_epoch != epoch_r);
  assign done_probe = hit || (!rd_pend_r && (n_iss_r == probe_limit));
  assign issue      = !done_probe && (n_iss_r != probe_limit);

  assign tally_inc    = (rd_tally == COUNT_MAX) ? rd_tally : rd_tally + 1'b1;
  assign new_tally    = hit ? tally_inc : COUNT_BITS'(1);
  assign ok           = hit || have_empty_r;
  assign items_inc    = (items_r == COUNT_MAX) ? items_r : items_r + 1'b1;
  assign best_upd     = (ok && (new_tally > best_tally_r)) ? new_tally : best_tally_r;
  assign best_key_upd = (ok && (new_tally > best_tally_r)) ? key_r : best_key_r;

  assign rem_shift = {rem_r, key_r[hash_idx_r]};
  assign rem_red   = (rem_shift >= TSIZE) ? rem_shift - TSIZE : rem_shift;
  assign pos_inc   = (pos_r == LAST_SLOT) ? '0 : pos_r + 1'b1;
  assign epoch_inc = epoch_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      rd_pend_r    <= 1'b0;
      clr_addr_r   <= '0;
      epoch_r      <= EPOCH_BITS'(1);
      items_r      <= '0;
      best_tally_r <= '0;
      best_key_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rd_pend_r    <= rd_pend_nxt;
      clr_addr_r   <= clr_addr_nxt;
      epoch_r      <= epoch_nxt;
      items_r      <= items_nxt;
      best_tally_r <= best_tally_nxt;
      best_key_r   <= best_key_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    last_r       <= last_nxt;
    pos_r        <= pos_nxt;
    chk_pos_r    <= chk_pos_nxt;
    n_iss_r      <= n_iss_nxt;
    have_empty_r <= have_empty_nxt;
    empty_pos_r  <= empty_pos_nxt;
    rem_r        <= rem_nxt;
    hash_idx_r   <= hash_idx_nxt;
    flags_r      <= flags_nxt;
    color_r      <= color_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    key_nxt        = key_r;
    last_nxt       = last_r;
    pos_nxt        = pos_r;
    chk_pos_nxt    = chk_pos_r;
    rd_pend_nxt    = 1'b0;
    n_iss_nxt      = n_iss_r;
    have_empty_nxt = have_empty_r;
    empty_pos_nxt  = empty_pos_r;
    rem_nxt        = rem_r;
    hash_idx_nxt   = hash_idx_r;
    clr_addr_nxt   = clr_addr_r;
    epoch_nxt      = epoch_r;
    items_nxt      = items_r;
    best_tally_nxt = best_tally_r;
    best_key_nxt   = best_key_r;
    out_valid_nxt  = 1'b0;
    flags_nxt      = flags_r;
    color_nxt      = color_r;
    ram_we         = 1'b0;
    ram_addr       = pos_r;
    ram_wdata      = '0;

    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_addr_r;
        ram_wdata = '0;
        if (clr_addr_r == LAST_SLOT) begin
          clr_addr_nxt = '0;
          epoch_nxt    = EPOCH_BITS'(1);
          state_nxt    = ST_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + 1'b1;
        end
      end

      ST_IDLE: begin
        if (start) begin
          key_nxt        = in_color;
          last_nxt       = in_last;
          n_iss_nxt      = '0;
          have_empty_nxt = 1'b0;
          if (POW2) begin
            pos_nxt   = key_ext[ADDR_BITS-1:0];
            state_nxt = ST_PROBE;
          end else begin
            rem_nxt      = '0;
            hash_idx_nxt = KIDX'(KEY_BITS - 1);
            state_nxt    = ST_HASH;
          end
        end
      end

      // Home slot by restoring reduction, one key bit per cycle, MSB first.
      ST_HASH: begin
        rem_nxt = rem_red[ADDR_BITS-1:0];
        if (hash_idx_r == '0) begin
          pos_nxt   = rem_red[ADDR_BITS-1:0];
          state_nxt = ST_PROBE;
        end else begin
          hash_idx_nxt = hash_idx_r - 1'b1;
        end
      end

      ST_PROBE: begin
        // Reads stream one per cycle; the word for chk_pos_r arrives now.
        if (empty_now) begin
          have_empty_nxt = 1'b1;
          empty_pos_nxt  = chk_pos_r;
        end
        if (issue) begin
          ram_addr    = pos_r;
          chk_pos_nxt = pos_r;
          rd_pend_nxt = 1'b1;
          pos_nxt     = pos_inc;
          n_iss_nxt   = n_iss_r + 1'b1;
        end
        if (done_probe) begin
          ram_we    = ok;
          ram_addr  = hit ? chk_pos_r : empty_pos_r;
          ram_wdata = {epoch_r, key_r, new_tally};

          out_valid_nxt          = 1'b1;
          flags_nxt.stored_ok    = ok;
          flags_nxt.end_of_set   = last_r;
          flags_nxt.has_majority = last_r && (best_upd > (items_inc >> 1));
          color_nxt = (last_r && (best_upd > (items_inc >> 1))) ? best_key_upd : '0;

          if (last_r) begin
            items_nxt      = '0;
            best_tally_nxt = '0;
            best_key_nxt   = '0;
            epoch_nxt      = epoch_inc;
            // Set numbers have run out: wipe the table before reuse.
            state_nxt      = (epoch_inc == '0) ? ST_CLEAR : ST_IDLE;
          end else begin
            items_nxt      = items_inc;
            best_tally_nxt = best_upd;
            best_key_nxt   = best_key_upd;
            state_nxt      = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_flags = flags_r;
  assign out_color = color_r;

endmodule

// ===== rtl/hash_count_majority_top.sv =====
// ----------------------------------------------------------------------------
// hash_count_majority_top
// Key frequency counter over a linear-probing slot table with majority check.
// ----------------------------------------------------------------------------
// A word is probed over up to probe_limit slots from its home slot; a hit
//   ends the probe early, and a non power of two table adds a hashing step
//   before probing. The block takes a new word only when it is through with
//   the last one and busy is low again.
// Reset clears the table in a pass over every slot while busy stays high; the
//   same pass runs after every 2^EPOCH_BITS - 1 sets. Results cannot stall.
module hash_count_majority_top
  import hcm_pkg::*;
#(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [KEY_BITS-1:0]   in_color,
  input  logic                  in_last,
  output logic                  out_valid,
  output logic                  out_stored_ok,
  output logic                  out_end_of_set,
  output logic                  out_has_majority,
  output logic [KEY_BITS-1:0]   out_majority_color,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [PROBE_BITS-1:0] cfg_data
);

  localparam int ADDR_BITS = $clog2(TABLE_SIZE);
  localparam int WORD_BITS = EPOCH_BITS + KEY_BITS + COUNT_BITS;

  logic [PROBE_BITS-1:0] probe_limit_r;
  logic                  ram_we;
  logic [ADDR_BITS-1:0]  ram_addr;
  logic [WORD_BITS-1:0]  ram_wdata;
  logic [WORD_BITS-1:0]  ram_rdata;
  hcm_flags_t            flags;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_limit_r <= PROBE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      probe_limit_r <= cfg_data;
    end
  end

  hcm_slot_ram #(
    .DEPTH (TABLE_SIZE),
    .WIDTH (WORD_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  hcm_engine #(
    .TABLE_SIZE (TABLE_SIZE),
    .KEY_BITS   (KEY_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_color    (in_color),
    .in_last     (in_last),
    .probe_limit (probe_limit_r),
    .ram_we      (ram_we),
    .ram_addr    (ram_addr),
    .ram_wdata   (ram_wdata),
    .ram_rdata   (ram_rdata),
    .out_valid   (out_valid),
    .out_flags   (flags),
    .out_color   (out_majority_color)
  );

  assign out_stored_ok    = flags.stored_ok;
  assign out_end_of_set   = flags.end_of_set;
  assign out_has_majority = flags.has_majority;

endmodule

// ===== rtl/hcm_checker.sv =====
// ----------------------------------------------------------------------------
// hcm_checker
// Port-level checks of the hash count majority block, bound to the top.
// ----------------------------------------------------------------------------
module hcm_checker
  import hcm_pkg::*;
#(
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input logic                out_has_majority,
  input logic                out_end_of_set,
  input logic [KEY_BITS-1:0] out_majority_color
);

  // An accepted word keeps the block busy in the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting a word");

  // The block works on one word at a time, so results never come back to back.
  a_no_double: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("two results in consecutive cycles");

  // A result is only produced by work that was under way in the prior cycle.
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without preceding work");

  // Majority is only reported at the end of a set.
  a_majority_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_end_of_set) |-> (!out_has_majority && (out_majority_color == '0)))
    else $error("majority reported before end of set");

endmodule

bind hash_count_majority_top hcm_checker #(
  .KEY_BITS (KEY_BITS)
) u_hcm_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .out_valid          (out_valid),
  .out_has_majority   (out_has_majority),
  .out_end_of_set     (out_end_of_set),
  .out_majority_color (out_majority_color)
);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for hash_count_majority_top. Sets of keys are sent with
// or without random gaps, and every result is compared with a software copy
// of the slot table, the set counters and the probe window register.
// ----------------------------------------------------------------------------
module tb;
  import hcm_pkg::*;

  localparam int TABLE_SIZE = TABLE_SIZE_DEF;
  localparam int KEY_BITS   = KEY_BITS_DEF;
  localparam int COUNT_BITS = COUNT_BITS_DEF;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 40;

  typedef struct packed {
    logic                stored_ok;
    logic                end_of_set;
    logic                has_majority;
    logic [KEY_BITS-1:0] majority_color;
  } tally_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [KEY_BITS-1:0]   in_color;
  logic                  in_last;
  logic                  out_valid;
  logic                  out_stored_ok;
  logic                  out_end_of_set;
  logic                  out_has_majority;
  logic [KEY_BITS-1:0]   out_majority_color;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [PROBE_BITS-1:0] cfg_data;

  // Software copy of the block state.
  logic [PROBE_BITS-1:0] probe_len;
  bit                    tbl_valid [TABLE_SIZE];
  logic [KEY_BITS-1:0]   tbl_key   [TABLE_SIZE];
  logic [COUNT_BITS-1:0] tbl_tally [TABLE_SIZE];
  logic [COUNT_BITS-1:0] set_items;
  logic [COUNT_BITS-1:0] best_tally;
  logic [KEY_BITS-1:0]   best_key;

  tally_result_t pending_results[$];
  tally_result_t due;
  int            fail_count = 0;

  hash_count_majority_top u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_color           (in_color),
    .in_last            (in_last),
    .out_valid          (out_valid),
    .out_stored_ok      (out_stored_ok),
    .out_end_of_set     (out_end_of_set),
    .out_has_majority   (out_has_majority),
    .out_majority_color (out_majority_color),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_data           (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #12_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic void clear_set();
    foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
    set_items  = '0;
    best_tally = '0;
    best_key   = '0;
  endfunction

  // A tie never displaces the current leader.
  function automatic void note_best(logic [KEY_BITS-1:0] key, logic [COUNT_BITS-1:0] tally);
    if (tally > best_tally) begin
      best_tally = tally;
      best_key   = key;
    end
  endfunction

  // Counts one key and returns the result the block should give for it.
  function automatic tally_result_t count_key(logic [KEY_BITS-1:0] key, logic last);
    tally_result_t res;
    int unsigned   pos;
    int unsigned   empty_pos;
    bit            have_empty;
    bit            found;
    res        = '0;
    pos        = key % TABLE_SIZE;
    empty_pos  = 0;
    have_empty = 1'b0;
    found      = 1'b0;
    // Empty slots do not end the search; the last one seen takes a new key.
    for (int n = 0; n < int'(probe_len) && !found; n++) begin
      if (!tbl_valid[pos]) begin
        empty_pos  = pos;
        have_empty = 1'b1;
      end else if (tbl_key[pos] == key) begin
        if (tbl_tally[pos] != COUNT_MAX) tbl_tally[pos] = tbl_tally[pos] + 1'b1;
        note_best(key, tbl_tally[pos]);
        found = 1'b1;
      end
      pos = (pos + 1) % TABLE_SIZE;
    end
    if (!found && have_empty) begin
      tbl_valid[empty_pos] = 1'b1;
      tbl_key[empty_pos]   = key;
      tbl_tally[empty_pos] = COUNT_BITS'(1);
      note_best(key, COUNT_BITS'(1));
      found = 1'b1;
    end
    if (set_items != COUNT_MAX) set_items = set_items + 1'b1;
    res.stored_ok  = found;
    res.end_of_set = last;
    if (last && best_tally > (set_items >> 1)) begin
      res.has_majority   = 1'b1;
      res.majority_color = best_key;
    end
    if (last) clear_set();
    return res;
  endfunction

  function automatic void check_field(string name, logic [KEY_BITS-1:0] want,
                                      logic [KEY_BITS-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  // Checks results and tracks accepted words and register writes.
  always @(posedge clk) begin
    if (!rst_n) begin
      probe_len = PROBE_RESET;
      clear_set();
      pending_results.delete();
    end else begin
      if (out_valid) begin
        if (pending_results.size() == 0) begin
          $error("result with none pending: stored_ok %0b end_of_set %0b",
                 out_stored_ok, out_end_of_set);
          fail_count++;
        end else begin
          due = pending_results.pop_front();
          check_field("stored_ok", KEY_BITS'(due.stored_ok), KEY_BITS'(out_stored_ok));
          check_field("end_of_set", KEY_BITS'(due.end_of_set), KEY_BITS'(out_end_of_set));
          check_field("has_majority", KEY_BITS'(due.has_majority),
                      KEY_BITS'(out_has_majority));
          check_field("majority_color", due.majority_color, out_majority_color);
        end
      end
      if (start && !busy) pending_results.push_back(count_key(in_color, in_last));
      if (cfg_valid && cfg_ready) probe_len = cfg_data;
    end
  end

  // Leaves start high so that the next word can follow without a gap.
  task automatic send_word(logic [KEY_BITS-1:0] color, logic last);
    start    <= 1'b1;
    in_color <= color;
    in_last  <= last;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic idle_gap(int cycles);
    start    <= 1'b0;
    in_color <= KEY_BITS'($urandom);
    in_last  <= 1'($urandom);
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_probe(logic [PROBE_BITS-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Most words repeat a lead key or land near one home slot, so that the
  // window fills, wraps and gets searched past empty slots.
  task automatic send_set(int len, bit gaps);
    logic [KEY_BITS-1:0] lead_key;
    logic [KEY_BITS-1:0] key;
    int                  home;
    int                  pick;
    lead_key = KEY_BITS'($urandom);
    if ($urandom_range(0, 3) == 0) home = $urandom_range(TABLE_SIZE - 12, TABLE_SIZE - 1);
    else home = $urandom_range(0, TABLE_SIZE - 1);
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) key = lead_key;
      else if (pick < 85)
        key = KEY_BITS'((home + $urandom_range(0, 20)) % TABLE_SIZE
                        + TABLE_SIZE * $urandom_range(0, 15));
      else key = KEY_BITS'($urandom);
      if (gaps && $urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 19));
      send_word(key, i == len - 1);
    end
  endtask

  // Short sets keep the set number wrapping within the run.
  task automatic run_sets(int total, bit gaps);
    int sent;
    int len;
    sent = 0;
    while (sent < total) begin
      if ($urandom_range(0, 39) == 0) len = $urandom_range(20, 120);
      else len = $urandom_range(1, 8);
      send_set(len, gaps && $urandom_range(0, 2) != 0);
      sent += len;
      if (gaps && $urandom_range(0, 15) == 0) drain();
    end
  endtask

  task automatic test_reset_window();
    // Repeats, the largest key and a second key sharing the home slot.
    send_word(16'h0000, 1'b0);
    send_word(16'h0000, 1'b0);
    send_word(16'hFFFF, 1'b0);
    send_word(16'd4096, 1'b0);
    send_word(16'h0000, 1'b1);
    // The second key lands at the far end and is found past empty slots;
    // the final tie leaves no majority.
    send_word(16'd100, 1'b0);
    send_word(16'd4196, 1'b0);
    send_word(16'd4196, 1'b0);
    send_word(16'd100, 1'b1);
    send_word(16'hFFFF, 1'b1);
    // The window wraps from the top slot to the bottom of the table.
    send_word(16'd4095, 1'b0);
    send_word(16'd8191, 1'b0);
    send_word(16'd12287, 1'b0);
    send_word(16'd8191, 1'b1);
  endtask

  task automatic test_window_extremes();
    // With no slot examined nothing is stored, yet the words still count.
    write_probe(5'd0);
    send_word(16'd5, 1'b0);
    send_word(16'd5, 1'b1);
    write_probe(5'd1);
    send_word(16'd7, 1'b0);
    send_word(16'd4103, 1'b0);
    send_word(16'd7, 1'b1);
    // A window longer than usual revisits nothing here but reaches far.
    write_probe(5'd31);
    send_word(16'd20, 1'b0);
    send_word(16'd4116, 1'b0);
    send_word(16'd8212, 1'b0);
    send_word(16'd4116, 1'b1);
  endtask

  task automatic test_default_window();
    write_probe(PROBE_RESET);
    run_sets(400, 1'b1);
  endtask

  task automatic test_narrow_window();
    write_probe(5'd1);
    run_sets(200, 1'b1);
    write_probe(5'd2);
    run_sets(150, 1'b1);
  endtask

  task automatic test_wide_window();
    write_probe(5'd16);
    run_sets(400, 1'b1);
  endtask

  task automatic test_random_windows();
    repeat (5) begin
      write_probe(PROBE_BITS'($urandom_range(0, 31)));
      run_sets(80, 1'b1);
    end
  endtask

  task automatic test_back_to_back();
    write_probe(PROBE_BITS'($urandom_range(1, 16)));
    run_sets(300, 1'b0);
  endtask

  initial begin
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_color  <= '0;
    in_last   <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_window();
    test_window_extremes();
    test_default_window();
    test_narrow_window();
    test_wide_window();
    test_random_windows();
    test_back_to_back();
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
